>>> hw/rtl/rlcdc_pkg.sv
// ----------------------------------------------------------------------------
// rlcdc_pkg
// Shared types, constants and helpers of the run-length codec.
// ----------------------------------------------------------------------------
package rlcdc_pkg;

  localparam int unsigned MaxRunDefault = 64;
  localparam int unsigned LenW          = 7;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiNine  = 8'h39;
  localparam logic [7:0] AsciiUpA   = 8'h41;
  localparam logic [7:0] AsciiUpZ   = 8'h5A;
  localparam logic [7:0] AsciiLowA  = 8'h61;
  localparam logic [7:0] AsciiLowZ  = 8'h7A;

  // Kind of the first piece of work an accepted byte starts
  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_RUN,
    JOB_REP,
    JOB_ERR
  } job_e;

  typedef struct packed {
    logic accept;
    logic emit;
    logic sel_tens;
    logic sel_units;
    logic sel_err;
    logic dec;
    logic load_end;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    job_e first_job;
    logic first_ge10;
    logic first_gt1;
    logic end_pend;
    logic end_ge10;
    logic end_gt1;
    logic cur_one;
    logic out_free;
  } dp_stat_t;

  // Tens digit of a run length of at most 64
  function automatic logic [2:0] tens_digit(input logic [LenW-1:0] len);
    logic [2:0] t;
    t = 3'd0;
    for (int i = 1; i <= 6; i++) begin
      if (len >= LenW'(10 * i)) begin
        t = 3'(i);
      end
    end
    return t;
  endfunction

endpackage

>>> hw/rtl/run_length_codec_decimal_count.sv
// ----------------------------------------------------------------------------
// run_length_codec_decimal_count
// Byte-stream run-length codec with ASCII decimal counts.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we_i/cfg_wdata_i write the mode while the block is idle:
//   0 compresses runs into count-digit/byte groups, 1 expands them.
//   s_axis carries one byte per request in tdata; tlast marks the final
//   byte of a stream and flushes any held run.
//   m_axis returns result bytes; tlast marks the final result caused by a
//   request, tuser[0] flags a too-large count, tuser[1] the final result
//   of the whole stream.
// Timing:
//   A request is accepted only when the controller is idle. Each result then
//   passes through the output register; a request yields N results (N up to
//   MAX_RUN + 3 while expanding with a compressed run still held, up to four
//   while compressing), and the controller takes no new request until its
//   final result is emitted.
//   The result sequencer emits one byte per cycle while m_axis is not stalled.
// Reset clears the mode to compress and drops all held state.
// When m_axis stalls, the current result holds and sequencing pauses.
// ----------------------------------------------------------------------------
module run_length_codec_decimal_count #(
  parameter int unsigned MAX_RUN = rlcdc_pkg::MaxRunDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // stream_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // last_of_burst
  output logic [1:0] m_axis_tuser_o    // [0] count_error, [1] end_of_output
);
  import rlcdc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     err, eoo;

  rlcdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rlcdc_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (s_axis_tdata_i),
    .in_end_i    (s_axis_tlast_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_err_o   (err),
    .out_eoo_o   (eoo),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign m_axis_tuser_o = {eoo, err};

endmodule

>>> hw/rtl/rlcdc_dp.sv
// ----------------------------------------------------------------------------
// rlcdc_dp
// Datapath: codec state, pending run/repeat work and the output register.
// ----------------------------------------------------------------------------
module rlcdc_dp #(
  parameter int unsigned MAX_RUN = rlcdc_pkg::MaxRunDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic [7:0]         in_byte_i,
  input  logic               in_end_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic               out_err_o,
  output logic               out_eoo_o,
  input  rlcdc_pkg::dp_cmd_t cmd_i,
  output rlcdc_pkg::dp_stat_t stat_o
);
  import rlcdc_pkg::*;

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_RUN);
  localparam logic [9:0]      SatVal = 10'(MAX_RUN + 1);

  logic            mode_q;
  logic [7:0]      held_q, held_d;
  logic            holding_q, holding_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] count_q, count_d;
  logic            digits_q, digits_d;

  logic [7:0]      cur_byte_q;
  logic [LenW-1:0] cur_len_q;
  logic [7:0]      end_byte_q;
  logic [LenW-1:0] end_len_q;
  logic            end_pend_q;
  logic            endf_q;

  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q, out_err_q, out_eoo_q;

  logic            is_digit, is_letter, cont, a_run, a_rep, a_err, b_run;
  logic [LenW-1:0] rep_cnt, first_len;
  logic [7:0]      first_byte;
  logic [9:0]      prod;
  job_e            first_job;

  logic [2:0]      tens;
  logic [LenW-1:0] units_full;
  logic [7:0]      res_byte;

  assign is_digit  = (in_byte_i >= AsciiZero) && (in_byte_i <= AsciiNine);
  assign is_letter = ((in_byte_i >= AsciiUpA) && (in_byte_i <= AsciiUpZ)) ||
                     ((in_byte_i >= AsciiLowA) && (in_byte_i <= AsciiLowZ));

  assign cont  = holding_q && (in_byte_i == held_q) && (len_q < MaxLen);
  assign a_run = !mode_q && holding_q && !cont;
  assign a_err = mode_q && is_letter && digits_q && (count_q > MaxLen);
  assign a_rep = mode_q && is_letter &&
                 (!digits_q || ((count_q != '0) && (count_q <= MaxLen)));
  assign rep_cnt = digits_q ? count_q : LenW'(1);

  // count * 10 + digit, saturated just above the largest legal run
  assign prod = {count_q, 3'b000} + {2'b00, count_q, 1'b0} +
                {6'd0, in_byte_i[3:0]};

  always_comb begin
    holding_d = holding_q;
    held_d    = held_q;
    len_d     = len_q;
    count_d   = count_q;
    digits_d  = digits_q;
    if (!mode_q) begin
      holding_d = 1'b1;
      held_d    = cont ? held_q : in_byte_i;
      len_d     = cont ? len_q + LenW'(1) : LenW'(1);
    end else if (is_digit) begin
      count_d  = (prod > SatVal - 10'd1) ? SatVal[LenW-1:0] : prod[LenW-1:0];
      digits_d = 1'b1;
    end else if (is_letter) begin
      count_d  = '0;
      digits_d = 1'b0;
    end
  end

  assign b_run = in_end_i && holding_d;

  always_comb begin
    first_job  = JOB_NONE;
    first_byte = held_d;
    first_len  = len_d;
    if (a_run) begin
      first_job  = JOB_RUN;
      first_byte = held_q;
      first_len  = len_q;
    end else if (a_rep) begin
      first_job  = JOB_REP;
      first_byte = in_byte_i;
      first_len  = rep_cnt;
    end else if (a_err) begin
      first_job  = JOB_ERR;
    end else if (b_run) begin
      first_job  = JOB_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      held_q    <= '0;
      holding_q <= 1'b0;
      len_q     <= '0;
      count_q   <= '0;
      digits_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        if (in_end_i) begin
          held_q    <= '0;
          holding_q <= 1'b0;
          len_q     <= '0;
          count_q   <= '0;
          digits_q  <= 1'b0;
        end else begin
          held_q    <= held_d;
          holding_q <= holding_d;
          len_q     <= len_d;
          count_q   <= count_d;
          digits_q  <= digits_d;
        end
      end
    end
  end

  // Pending work of the accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_pend_q <= 1'b0;
      endf_q     <= 1'b0;
    end else if (cmd_i.accept) begin
      end_pend_q <= b_run && (a_run || a_rep || a_err);
      endf_q     <= in_end_i;
    end else if (cmd_i.load_end) begin
      end_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_byte_q <= first_byte;
      cur_len_q  <= first_len;
      end_byte_q <= held_d;
      end_len_q  <= len_d;
    end else if (cmd_i.load_end) begin
      cur_byte_q <= end_byte_q;
      cur_len_q  <= end_len_q;
    end else if (cmd_i.dec) begin
      cur_len_q  <= cur_len_q - LenW'(1);
    end
  end

  assign tens       = tens_digit(cur_len_q);
  assign units_full = cur_len_q - ({1'b0, tens, 3'b000} + {3'b000, tens, 1'b0});

  always_comb begin
    res_byte = cur_byte_q;
    if (cmd_i.sel_err) begin
      res_byte = 8'h00;
    end else if (cmd_i.sel_tens) begin
      res_byte = AsciiZero + {5'd0, tens};
    end else if (cmd_i.sel_units) begin
      res_byte = AsciiZero + {4'd0, units_full[3:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= res_byte;
      out_last_q <= cmd_i.last;
      out_err_q  <= cmd_i.sel_err;
      out_eoo_q  <= cmd_i.last && endf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;
  assign out_eoo_o   = out_eoo_q;

  assign stat_o.first_job  = first_job;
  assign stat_o.first_ge10 = first_len >= LenW'(10);
  assign stat_o.first_gt1  = first_len > LenW'(1);
  assign stat_o.end_pend   = end_pend_q;
  assign stat_o.end_ge10   = end_len_q >= LenW'(10);
  assign stat_o.end_gt1    = end_len_q > LenW'(1);
  assign stat_o.cur_one    = cur_len_q == LenW'(1);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

endmodule

>>> hw/rtl/rlcdc_ctrl.sv
// ----------------------------------------------------------------------------
// rlcdc_ctrl
// Controller: accepts a request, then sequences its results one per slot.
// ----------------------------------------------------------------------------
module rlcdc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rlcdc_pkg::dp_stat_t stat_i,
  output rlcdc_pkg::dp_cmd_t  cmd_o
);
  import rlcdc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TENS  = 6'b000010,
    S_UNITS = 6'b000100,
    S_BYTE  = 6'b001000,
    S_REP   = 6'b010000,
    S_ERR   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   final_res;

  function automatic state_e run_start(input logic ge10, input logic gt1);
    state_e s;
    if (ge10) begin
      s = S_TENS;
    end else if (gt1) begin
      s = S_UNITS;
    end else begin
      s = S_BYTE;
    end
    return s;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    final_res = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (stat_i.first_job)
            JOB_RUN: state_d = run_start(stat_i.first_ge10, stat_i.first_gt1);
            JOB_REP: state_d = S_REP;
            JOB_ERR: state_d = S_ERR;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_TENS: begin
        cmd_o.sel_tens = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_UNITS;
        end
      end
      S_UNITS: begin
        cmd_o.sel_units = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_BYTE;
        end
      end
      S_BYTE: begin
        final_res = 1'b1;
      end
      S_REP: begin
        final_res = stat_i.cur_one;
        if (stat_i.out_free) begin
          cmd_o.dec = 1'b1;
        end
      end
      S_ERR: begin
        cmd_o.sel_err = 1'b1;
        final_res     = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Results of BYTE, REP and ERR; on a job's closing result, chain to the end-of-stream flush if pending
    if ((state_q != S_IDLE) && (state_q != S_TENS) && (state_q != S_UNITS) &&
        stat_i.out_free) begin
      cmd_o.emit = 1'b1;
      if (final_res) begin
        cmd_o.last = !stat_i.end_pend;
        if (stat_i.end_pend) begin
          cmd_o.load_end = 1'b1;
          state_d        = run_start(stat_i.end_ge10, stat_i.end_gt1);
        end else begin
          state_d = S_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/rlcdc_checker.sv
// ----------------------------------------------------------------------------
// rlcdc_checker
// Port-level checks of the run-length codec, bound to the top level.
// ----------------------------------------------------------------------------
module rlcdc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic [1:0] m_axis_tuser_o
);

  // End of stream is always the closing result of its request
  a_eoo_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> m_axis_tlast_o)
    else $error("end of output without last of burst");

  // Error result carries a zero byte
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o == 8'h00))
    else $error("count error with nonzero byte");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
       $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind run_length_codec_decimal_count rlcdc_checker u_rlcdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
